// File: sv/gha_pkg.sv
// Shared types, command codes and GF(2^128) helper functions for the GHASH block.
// No dependencies; gha_front, gha_back and ghash_accumulator refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package gha_pkg;

    // Block width and digit split of the serial multiplier
    localparam int unsigned BLK_W     = 128;
    localparam int unsigned HALF_W    = 64;
    localparam int unsigned DIGIT_W   = 32;
    localparam int unsigned DIGITS    = BLK_W / DIGIT_W;
    localparam int unsigned DIGIT_CW  = $clog2(DIGITS);
    localparam int unsigned BLK_BYTES = 16;
    localparam int unsigned NBYTES_W  = 5;
    localparam int unsigned LEN_SHIFT = 3;

    // Command codes
    localparam logic [1:0] CMD_AAD    = 2'd0;
    localparam logic [1:0] CMD_TEXT   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SUBKEY_HIGH = 1'b0;
    localparam logic CFG_SUBKEY_LOW  = 1'b1;

    typedef logic [BLK_W-1:0] t_blk;

    // Reduction polynomial 1 + x + x^2 + x^7 in GCM bit order (bit 127 = x^0)
    localparam t_blk RED_POLY = {8'he1, 120'd0};

    // One queued operation: block to fold into Y, and whether Y is emitted after
    typedef struct packed {
        logic fin;
        t_blk blk;
    } t_op;

    // Multiply v by x^k (k from 0 to 32) in GF(2^128), GCM bit order
    function automatic t_blk gf_mulx(input t_blk v, input int unsigned k);
        t_blk        r;
        int unsigned m;
        r = v >> k;
        for (int unsigned t = 0; t < 32; t++) begin
            if (t < k) begin
                m = k - 1 - t;
                if (v[t]) begin
                    r = r ^ (RED_POLY >> m);
                end
            end
        end
        return r;
    endfunction

    // Carry-less product of v with one digit of X; digit bit DIGIT_W-1 is the lowest power
    function automatic t_blk gf_digit_mul(input t_blk v, input logic [DIGIT_W-1:0] d);
        t_blk acc;
        acc = '0;
        for (int unsigned j = 0; j < DIGIT_W; j++) begin
            if (d[DIGIT_W-1-j]) begin
                acc = acc ^ gf_mulx(v, j);
            end
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

// File: sv/gha_fifo.sv
// Small first-in first-out queue built from registers.
// Used between front and back and for finished hash values; no package use.
`timescale 1ns / 1ps
`default_nettype none
module gha_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // Store incoming item
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/gha_front.sv
// Front end: classifies accepted items, pads blocks, keeps the length counters.
// Depends on gha_pkg; feeds t_op queue entries to the multiplier back end.
`timescale 1ns / 1ps
`default_nettype none
module gha_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [gha_pkg::HALF_W-1:0]    i_block_high,
    input  wire logic [gha_pkg::HALF_W-1:0]    i_block_low,
    input  wire logic [gha_pkg::NBYTES_W-1:0]  i_valid_bytes,
    output logic                               o_op_write,
    output gha_pkg::t_op                       o_op
);
    localparam logic [gha_pkg::NBYTES_W-1:0] MAX_BYTES =
        gha_pkg::NBYTES_W'(gha_pkg::BLK_BYTES);

    logic [gha_pkg::HALF_W-1:0]   r_aad_cnt, r_text_cnt;
    logic [gha_pkg::NBYTES_W-1:0] nbytes;
    gha_pkg::t_blk                mask;
    logic                         is_absorb, is_finish, keep;

    // Clamp the byte count and build the padding mask
    always_comb begin
        nbytes = (i_valid_bytes > MAX_BYTES) ? MAX_BYTES : i_valid_bytes;
        mask   = '0;
        for (int unsigned b = 0; b < gha_pkg::BLK_BYTES; b++) begin
            if (gha_pkg::NBYTES_W'(b) < nbytes) begin
                mask[gha_pkg::BLK_W-1-8*b -: 8] = 8'hff;
            end
        end
    end

    // Classify: drop unused codes and empty absorbs
    always_comb begin
        is_absorb = ((i_cmd == gha_pkg::CMD_AAD) || (i_cmd == gha_pkg::CMD_TEXT))
                    && (i_valid_bytes != '0);
        is_finish = (i_cmd == gha_pkg::CMD_FINISH);
        keep      = is_absorb || is_finish;
    end

    // Build the queue entry
    always_comb begin
        o_op_write = i_accept && keep;
        o_op.fin   = is_finish;
        if (is_finish) begin
            o_op.blk = {r_aad_cnt[gha_pkg::HALF_W-1-gha_pkg::LEN_SHIFT:0],
                        {gha_pkg::LEN_SHIFT{1'b0}},
                        r_text_cnt[gha_pkg::HALF_W-1-gha_pkg::LEN_SHIFT:0],
                        {gha_pkg::LEN_SHIFT{1'b0}}};
        end else begin
            o_op.blk = {i_block_high, i_block_low} & mask;
        end
    end

    // Advance byte counters; clear them on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aad_cnt  <= '0;
            r_text_cnt <= '0;
        end else if (i_accept) begin
            if (is_finish) begin
                r_aad_cnt  <= '0;
                r_text_cnt <= '0;
            end else if (is_absorb && (i_cmd == gha_pkg::CMD_AAD)) begin
                r_aad_cnt  <= r_aad_cnt + gha_pkg::HALF_W'(nbytes);
            end else if (is_absorb) begin
                r_text_cnt <= r_text_cnt + gha_pkg::HALF_W'(nbytes);
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/gha_back.sv
// Back end: digit-serial GF(2^128) multiply Y = (Y ^ block) * H, 32 bits of X a cycle.
// Depends on gha_pkg; takes t_op entries and pushes finished hash values.
`timescale 1ns / 1ps
`default_nettype none
module gha_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gha_pkg::t_blk i_subkey,
    input  wire logic          i_op_valid,
    input  wire gha_pkg::t_op  i_op,
    input  wire logic          i_res_full,
    output logic               o_op_take,
    output logic               o_res_push,
    output gha_pkg::t_blk      o_res
);
    localparam logic [gha_pkg::DIGIT_CW-1:0] LAST_DIGIT =
        gha_pkg::DIGIT_CW'(gha_pkg::DIGITS - 1);

    logic                            r_busy, r_fin;
    logic [gha_pkg::DIGIT_CW-1:0]    r_digit;
    gha_pkg::t_blk                   r_y, r_x, r_z, r_v;
    gha_pkg::t_blk                   n_z, n_y, y_now;
    logic                            last, res_ok;

    // Fold one digit of X into the partial product
    always_comb begin
        n_z = r_z ^ gha_pkg::gf_digit_mul(r_v,
                  r_x[gha_pkg::BLK_W-1 -: gha_pkg::DIGIT_W]);
    end

    assign last       = r_busy && (r_digit == LAST_DIGIT);
    assign n_y        = r_fin ? '0 : n_z;
    assign y_now      = last ? n_y : r_y;
    assign o_res_push = last && r_fin;
    assign o_res      = n_z;
    // A finish may start only when its result is sure to find room
    assign res_ok     = !i_op.fin || (!i_res_full && !(last && r_fin));
    assign o_op_take  = i_op_valid && (!r_busy || last) && res_ok;

    // Control: busy flag and digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_digit <= '0;
            r_y     <= '0;
        end else begin
            if (last) begin
                r_y <= n_y;
            end
            if (o_op_take) begin
                r_busy  <= 1'b1;
                r_digit <= '0;
            end else if (last) begin
                r_busy  <= 1'b0;
            end else if (r_busy) begin
                r_digit <= r_digit + 1'b1;
            end
        end
    end

    // Datapath: load a new operand or advance one digit
    always_ff @(posedge i_clk) begin
        if (o_op_take) begin
            r_x   <= y_now ^ i_op.blk;
            r_z   <= '0;
            r_v   <= i_subkey;
            r_fin <= i_op.fin;
        end else if (r_busy) begin
            r_x <= r_x << gha_pkg::DIGIT_W;
            r_z <= n_z;
            r_v <= gha_pkg::gf_mulx(r_v, gha_pkg::DIGIT_W);
        end
    end
endmodule
`default_nettype wire

// File: sv/ghash_accumulator.sv
// GHASH accumulator for GCM. Items enter through a push/full queue port and
// finished hash values leave through an empty/pop queue port. A front end pads
// each absorb block, keeps the AAD and text byte counters and turns a finish into
// the length block; a small queue then hands work to a multiplier that computes
// Y = (Y ^ block) * H over GF(2^128) one 32-bit digit of the operand per cycle.
// Every absorb and every finish occupies the multiplier for all digits of its
// operand, and the next item is taken as its last digit is folded; a finish that
// comes straight after another finish waits until that one has pushed its result,
// and a finish also waits while the result queue is full. Items with an unused
// command and absorbs with zero valid bytes are dropped at the front and cost
// nothing there. A result is pushed as the last digit of its finish is folded.
// Write the subkey halves only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module ghash_accumulator #(
    parameter int unsigned OP_DEPTH  = 2,
    parameter int unsigned RES_DEPTH = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [gha_pkg::HALF_W-1:0]    i_block_high,
    input  wire logic [gha_pkg::HALF_W-1:0]    i_block_low,
    input  wire logic [gha_pkg::NBYTES_W-1:0]  i_valid_bytes,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [gha_pkg::HALF_W-1:0]         o_hash_high,
    output logic [gha_pkg::HALF_W-1:0]         o_hash_low,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [gha_pkg::HALF_W-1:0]    i_cfg_wdata
);
    logic [gha_pkg::HALF_W-1:0] r_subkey_high, r_subkey_low;
    logic                       accept, op_write, op_take, op_empty, op_full;
    logic                       res_push, res_full;
    gha_pkg::t_op               op_in, op_out;
    gha_pkg::t_blk              res_in, res_out;

    assign accept = push && !full;
    assign full   = op_full;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subkey_high <= '0;
            r_subkey_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gha_pkg::CFG_SUBKEY_HIGH: r_subkey_high <= i_cfg_wdata;
                gha_pkg::CFG_SUBKEY_LOW:  r_subkey_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    gha_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_block_high  (i_block_high),
        .i_block_low   (i_block_low),
        .i_valid_bytes (i_valid_bytes),
        .o_op_write    (op_write),
        .o_op          (op_in)
    );

    gha_fifo #(
        .WIDTH ($bits(gha_pkg::t_op)),
        .DEPTH (OP_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (op_write),
        .i_wdata (op_in),
        .i_rd    (op_take),
        .o_rdata (op_out),
        .o_full  (op_full),
        .o_empty (op_empty)
    );

    gha_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_subkey   ({r_subkey_high, r_subkey_low}),
        .i_op_valid (!op_empty),
        .i_op       (op_out),
        .i_res_full (res_full),
        .o_op_take  (op_take),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    gha_fifo #(
        .WIDTH (gha_pkg::BLK_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .i_rd    (pop),
        .o_rdata (res_out),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_hash_high = res_out[gha_pkg::BLK_W-1 -: gha_pkg::HALF_W];
    assign o_hash_low  = res_out[gha_pkg::HALF_W-1:0];
endmodule
`default_nettype wire

// File: sv/gha_checker.sv
// Port-level checks on the GHASH accumulator, attached by the bind below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module gha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [63:0] o_hash_high,
    input wire logic [63:0] o_hash_low
);
    // Reset leaves no result waiting
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // No result can come out straight after reset ends
    a_no_early_result: assert property (@(posedge i_clk)
        (!i_rst_n ##1 i_rst_n) |=> empty)
        else $error("result appeared too soon after reset");

    // Input side is open right after reset
    a_open_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full asserted after reset");

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_hash_high) && $stable(o_hash_low)))
        else $error("waiting result changed before pop");
endmodule

bind ghash_accumulator gha_checker u_gha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_hash_high (o_hash_high),
    .o_hash_low  (o_hash_low)
);
`default_nettype wire
